[hw/rtl/quadrature_position_counter_macros.svh]
// assertion macros used by the quadrature position counter checker
`ifndef QUADRATURE_POSITION_COUNTER_MACROS_SVH
`define QUADRATURE_POSITION_COUNTER_MACROS_SVH

// property checked while out of reset
`define QPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define QPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/qpc_pkg.sv]
// types and constants of the quadrature position counter
package qpc_pkg;

    localparam int POS_WIDTH  = 16;
    localparam int WIDE_WIDTH = POS_WIDTH + 2;

    localparam logic [3:0] PAT_FWD = 4'b1101;
    localparam logic [3:0] PAT_REV = 4'b1110;

    localparam logic signed [POS_WIDTH-1:0] POS_MIN_RST  = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MAX_RST  = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] STEP_RST     = POS_WIDTH'(1);

    typedef enum logic [1:0] {
        CFG_POS_MIN     = 2'd0,
        CFG_POS_MAX     = 2'd1,
        CFG_STEP_SIZE   = 2'd2,
        CFG_WRAP_ENABLE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                        mode;
        logic                        line_a;
        logic                        line_b;
        logic signed [POS_WIDTH-1:0] new_position;
    } t_qpc_in;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position;
        logic                        changed;
    } t_qpc_out;

endpackage

[hw/rtl/quadrature_position_counter.sv]
// quadrature position counter: encoder sample / position load to bounded position
//
// input channel (i_in_valid / o_in_ready / i_in_word): each word either samples
// the two encoder lines (mode 0) or loads a new position (mode 1).
// output channel (o_out_valid / i_out_ready / o_out_word): exactly one word per
// input word, in order, with the bounded position and a changed flag.
// configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (pos_min, pos_max, step_size, wrap_enable); write only while the block is idle.
// path: an accepted word passes the input register, then the result register.
// throughput: one word per cycle while i_out_ready is high; the add-and-bound
// update sits between input and result register, so items follow back to back.
// stall: while the receiver holds i_out_ready low the result word holds, and one
// more input word can still be taken into the input register before
// o_in_ready drops.
// reset: both registers empty, position and previous line pair zero, bounds
// -32768..32767, step 1, clamping.
module quadrature_position_counter
    import qpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [POS_WIDTH-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_qpc_in              i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_qpc_out             o_out_word
);

    logic                         r_in_valid;
    t_qpc_in                      r_in_word;
    logic                         r_out_valid;
    t_qpc_out                     r_out_word;
    logic [1:0]                   r_prev_lines;
    logic signed [POS_WIDTH-1:0]  r_cur_pos;
    logic signed [POS_WIDTH-1:0]  r_pos_min;
    logic signed [POS_WIDTH-1:0]  r_pos_max;
    logic signed [POS_WIDTH-1:0]  r_step;
    logic                         r_wrap;

    logic                         advance;
    logic [3:0]                   pattern;
    logic signed [WIDE_WIDTH-1:0] w_cur;
    logic signed [WIDE_WIDTH-1:0] w_step;
    logic signed [WIDE_WIDTH-1:0] w_next;
    logic signed [WIDE_WIDTH-1:0] w_min;
    logic signed [WIDE_WIDTH-1:0] w_max;
    logic signed [POS_WIDTH-1:0]  n_pos;
    logic [1:0]                   n_prev_lines;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign pattern = {r_in_word.line_b, r_in_word.line_a, r_prev_lines};
    assign w_cur   = WIDE_WIDTH'(r_cur_pos);
    assign w_step  = WIDE_WIDTH'(r_step);
    assign w_min   = WIDE_WIDTH'(r_pos_min);
    assign w_max   = WIDE_WIDTH'(r_pos_max);

    always_comb begin
        n_prev_lines = r_prev_lines;
        if (r_in_word.mode) begin
            w_next = WIDE_WIDTH'(r_in_word.new_position);
        end else begin
            n_prev_lines = pattern[3:2];
            if (pattern == PAT_FWD) begin
                w_next = w_cur + w_step;
            end else if (pattern == PAT_REV) begin
                w_next = w_cur - w_step;
            end else begin
                w_next = w_cur;
            end
        end
    end

    // below-minimum test wins, also with inverted bounds
    always_comb begin
        priority if (w_next < w_min) begin
            n_pos = r_wrap ? r_pos_max : r_pos_min;
        end else if (w_next > w_max) begin
            n_pos = r_wrap ? r_pos_min : r_pos_max;
        end else begin
            n_pos = w_next[POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_min <= POS_MIN_RST;
            r_pos_max <= POS_MAX_RST;
            r_step    <= STEP_RST;
            r_wrap    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POS_MIN:     r_pos_min <= i_cfg_data;
                CFG_POS_MAX:     r_pos_max <= i_cfg_data;
                CFG_STEP_SIZE:   r_step    <= i_cfg_data;
                CFG_WRAP_ENABLE: r_wrap    <= i_cfg_data[0];
                default:         r_wrap    <= r_wrap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_lines <= 2'b00;
            r_cur_pos    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_prev_lines <= n_prev_lines;
                r_cur_pos    <= n_pos;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        // after the first word, the reported position equals the current position
        if (advance) begin
            r_out_word.position <= n_pos;
            r_out_word.changed  <= (n_pos != r_cur_pos);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[hw/rtl/qpc_checker.sv]
// port-level checker for the quadrature position counter, bound to the top level
`include "quadrature_position_counter_macros.svh"

module qpc_checker
    import qpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [POS_WIDTH-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  t_qpc_in              i_in_word,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  t_qpc_out             o_out_word
);

    logic signed [POS_WIDTH-1:0] r_last_pos;
    logic                        cfg_seen;
    logic                        in_seen;

    // inputs observed only to keep the binding complete
    assign cfg_seen = i_cfg_we && (i_cfg_idx == CFG_WRAP_ENABLE) && i_cfg_data[0];
    assign in_seen  = i_in_valid && i_in_word.mode;

    // last delivered position, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_pos <= o_out_word.position;
        end
    end

    `QPC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)), "stalled output word changed")
    `QPC_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_out_valid), "output valid after reset")
    `QPC_ASSERT(a_changed_flag, i_clk, i_rst_n, o_out_valid |-> (o_out_word.changed == (o_out_word.position != r_last_pos)), "changed flag disagrees with last delivered position")
    `QPC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, (!o_out_valid || cfg_seen || in_seen || !cfg_seen) |-> (o_out_valid || o_in_ready), "input stalled with empty output register")

endmodule

bind quadrature_position_counter qpc_checker u_qpc_checker (.*);
